[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the spring force unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define DSF_CHECK(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("dsf check failed");

// Next-cycle implication, also evaluated during reset.
`define DSF_CHECK_NEXT(name, clk, cond, expr) \
  name: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("dsf next-cycle check failed");

`endif

[src/dsf_pkg.sv]
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared constants and types of the damped spring force unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

  // Default fixed-point format
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // Word field widths
  localparam int VEC_W    = 32;
  localparam int COEF_W   = 31;
  localparam int STATUS_W = 2;

  // Clamp applied to the strain and damping terms
  localparam logic [63:0] MID_LIMIT = 64'(1) << 61;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEN  = 2'd1,
    ST_ZERO_REST = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

endpackage

`default_nettype wire

[src/dsf_in_if.sv]
// ----------------------------------------------------------------------------
// dsf_in_if
// Spring word channel: valid/ready plus one spring description.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [dsf_pkg::VEC_W-1:0]   dpos_x;
  logic signed [dsf_pkg::VEC_W-1:0]   dpos_y;
  logic signed [dsf_pkg::VEC_W-1:0]   dpos_z;
  logic signed [dsf_pkg::VEC_W-1:0]   dvel_x;
  logic signed [dsf_pkg::VEC_W-1:0]   dvel_y;
  logic signed [dsf_pkg::VEC_W-1:0]   dvel_z;
  logic        [dsf_pkg::COEF_W-1:0]  rest_length;
  logic        [dsf_pkg::COEF_W-1:0]  stiffness;
  logic        [dsf_pkg::COEF_W-1:0]  damping;

  modport source (
    output valid, dpos_x, dpos_y, dpos_z, dvel_x, dvel_y, dvel_z,
           rest_length, stiffness, damping,
    input  ready
  );

  modport sink (
    input  valid, dpos_x, dpos_y, dpos_z, dvel_x, dvel_y, dvel_z,
           rest_length, stiffness, damping,
    output ready
  );
endinterface

`default_nettype wire

[src/dsf_out_if.sv]
// ----------------------------------------------------------------------------
// dsf_out_if
// Force word channel: valid/ready plus force vector and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dsf_pkg::VEC_W-1:0]    force_x;
  logic signed [dsf_pkg::VEC_W-1:0]    force_y;
  logic signed [dsf_pkg::VEC_W-1:0]    force_z;
  logic        [dsf_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, force_x, force_y, force_z, status,
    input  ready
  );

  modport sink (
    input  valid, force_x, force_y, force_z, status,
    output ready
  );
endinterface

`default_nettype wire

[src/damped_spring_force_unit.sv]
// ----------------------------------------------------------------------------
// damped_spring_force_unit
// Pipelined damped spring force: one spring word in, one force word out.
//
// springs: one word per spring (position and velocity differences, first body
//   minus second, rest length, stiffness, damping; fixed point).
// forces: force on the second body (the first gets its negation), saturated,
//   plus status (ok, zero length, zero rest length, saturated).
// DW = min(WORD_BITS, 32). The length is an integer square root resolved one
// bit per stage (DW stages); direction and strain come out of four restoring
// dividers run side by side, one quotient bit per stage (DW+FRAC_BITS stages);
// wide products are split in two halves and summed a stage later.
// Throughput is one word per cycle: a word can enter every cycle unless the
// output stalls.
// Reset clears all valid bits; no word is in flight afterward.
// When the sink holds ready low with a word waiting in the output register,
// the whole pipeline freezes and springs.ready drops in the same cycle;
// nothing is lost or repeated, and the pipe resumes when the word is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module damped_spring_force_unit #(
  parameter int FRAC_BITS = dsf_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = dsf_pkg::WORD_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dsf_in_if.sink     springs,
  dsf_out_if.source  forces
);

  // --------------------------------------------------------------------------
  // Widths
  // --------------------------------------------------------------------------
  localparam int DW   = (WORD_BITS > 32) ? 32 : WORD_BITS; // data width
  localparam int F    = FRAC_BITS;
  localparam int SW   = 2 * DW;          // sum of squares
  localparam int NW   = DW + F;          // dividend / quotient width
  localparam int DMW  = F + 1;           // direction magnitude (<= 1.0)
  localparam int EH   = (NW + 1) / 2;    // split point of strain magnitude
  localparam int EKW  = NW + DW - 1;     // strain * stiffness full product
  localparam int PSW  = F + DW + 3;      // sum of dir*vel products, signed
  localparam int RVW  = DW + 1;          // relative velocity magnitude
  localparam int RH   = (RVW + 1) / 2;
  localparam int RCW  = RVW + DW - 1;    // rv * damping full product
  localparam int SMW  = 63;              // magnitude of s (<= 2^62)
  localparam int SLO  = 32;              // split point of s magnitude
  localparam int FPW  = SMW + DMW;       // s * dir full product
  localparam int NLANE = 4;              // x, y, z direction, then strain
  localparam int LANE_E = 3;
  localparam int NST  = 16 + DW + NW;    // register stages, input to output

  localparam logic [63:0] HALF_RANGE = 64'(1) << (DW - 1);

  typedef struct packed {
    logic [2:0][DW-1:0] dmag;
    logic [2:0]         dneg;
    logic [2:0][DW-1:0] vel;
    logic [DW-2:0]      rest;
    logic [DW-2:0]      kst;
    logic [DW-2:0]      dmp;
    logic               zl;
    logic               zr;
  } side_t;

  typedef struct packed {
    logic [2:0][DMW-1:0] dirmag;
    logic [2:0]          dirneg;
    logic                zl;
    logic                zr;
    logic                sat;
    logic                sneg;
  } post_t;

  // --------------------------------------------------------------------------
  // Flow control: one global enable, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic           en;

  assign en            = !vld[NST-1] || forces.ready;
  assign springs.ready = en;
  assign forces.valid  = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], springs.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: narrow to DW, split into magnitude and sign
  // --------------------------------------------------------------------------
  side_t             in_side;
  logic [2:0][DW-1:0] raw_d;
  side_t             s0_side;

  always_comb begin
    raw_d[0] = springs.dpos_x[DW-1:0];
    raw_d[1] = springs.dpos_y[DW-1:0];
    raw_d[2] = springs.dpos_z[DW-1:0];
    for (int i = 0; i < 3; i++) begin
      in_side.dneg[i] = raw_d[i][DW-1];
      in_side.dmag[i] = raw_d[i][DW-1] ? (~raw_d[i] + DW'(1)) : raw_d[i];
    end
    in_side.vel[0] = springs.dvel_x[DW-1:0];
    in_side.vel[1] = springs.dvel_y[DW-1:0];
    in_side.vel[2] = springs.dvel_z[DW-1:0];
    in_side.rest   = springs.rest_length[DW-2:0];
    in_side.kst    = springs.stiffness[DW-2:0];
    in_side.dmp    = springs.damping[DW-2:0];
    in_side.zl     = (raw_d[0] == '0) && (raw_d[1] == '0) && (raw_d[2] == '0);
    in_side.zr     = (springs.rest_length[DW-2:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= in_side;
    end
  end

  // --------------------------------------------------------------------------
  // Squares, then their sum
  // --------------------------------------------------------------------------
  side_t         s1_side;
  logic [SW-1:0] s1_sq [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side <= s0_side;
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= s0_side.dmag[i] * s0_side.dmag[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Integer square root, one result bit per stage
  // --------------------------------------------------------------------------
  side_t         sq_side [0:DW];
  logic [SW-1:0] sq_rem  [0:DW];
  logic [DW-1:0] sq_root [0:DW];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= s1_side;
      sq_rem[0]  <= s1_sq[0] + s1_sq[1] + s1_sq[2];
      sq_root[0] <= '0;
    end
  end

  for (genvar j = 0; j < DW; j++) begin : g_sqrt
    localparam int K = DW - 1 - j;
    logic [SW:0] trial;
    logic        fits;

    always_comb begin
      trial = ((SW+1)'(sq_root[j]) << (K + 1)) | ((SW+1)'(1) << (2 * K));
      fits  = ((SW+1)'(sq_rem[j]) >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[j+1] <= sq_side[j];
        sq_rem[j+1]  <= fits ? (sq_rem[j] - trial[SW-1:0]) : sq_rem[j];
        sq_root[j+1] <= fits ? (sq_root[j] | (DW'(1) << K)) : sq_root[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup: |d_i| << F over length, |len - rest| << F over rest
  // --------------------------------------------------------------------------
  side_t         dv_side [0:NW];
  logic [DW-1:0] dv_len  [0:NW];
  logic          dv_eneg [0:NW];
  logic [DW-1:0] dv_rem  [0:NW][0:NLANE-1];
  logic [NW-1:0] dv_dq   [0:NW][0:NLANE-1];

  logic signed [DW:0] diff;
  logic [DW-1:0]      emag;

  always_comb begin
    diff = $signed({1'b0, sq_root[DW]}) - $signed({2'b00, sq_side[DW].rest});
    emag = diff[DW] ? DW'(-diff) : diff[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= sq_side[DW];
      dv_len[0]  <= sq_root[DW];
      dv_eneg[0] <= diff[DW];
      for (int l = 0; l < NLANE; l++) begin
        dv_rem[0][l] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        dv_dq[0][i] <= {sq_side[DW].dmag[i], F'(0)};
      end
      dv_dq[0][LANE_E] <= {emag, F'(0)};
    end
  end

  // Restoring division, one quotient bit per stage. The dividend shifts out
  // of the top of dq while quotient bits shift in at the bottom.
  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [DW:0]   part  [0:NLANE-1];
    logic [DW:0]   dsor  [0:NLANE-1];
    logic          take  [0:NLANE-1];

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        dsor[l] = (l == LANE_E) ? {2'b00, dv_side[j].rest} : {1'b0, dv_len[j]};
        part[l] = {dv_rem[j][l], dv_dq[j][l][NW-1]};
        take[l] = (part[l] >= dsor[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[j+1] <= dv_side[j];
        dv_len[j+1]  <= dv_len[j];
        dv_eneg[j+1] <= dv_eneg[j];
        for (int l = 0; l < NLANE; l++) begin
          dv_rem[j+1][l] <= take[l] ? DW'(part[l] - dsor[l]) : part[l][DW-1:0];
          dv_dq[j+1][l]  <= {dv_dq[j][l][NW-2:0], take[l]};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Signed direction
  // --------------------------------------------------------------------------
  post_t               sg_post;
  logic signed [F+1:0] sg_dir [0:2];
  logic [2:0][DW-1:0]  sg_vel;
  logic [NW-1:0]       sg_emag;
  logic                sg_eneg;
  logic [DW-2:0]       sg_kst;
  logic [DW-2:0]       sg_dmp;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sg_post.dirmag[i] <= dv_dq[NW][i][DMW-1:0];
        sg_post.dirneg[i] <= dv_side[NW].dneg[i] && (dv_dq[NW][i][DMW-1:0] != '0);
        sg_dir[i] <= dv_side[NW].dneg[i] ? -$signed({1'b0, dv_dq[NW][i][DMW-1:0]})
                                         :  $signed({1'b0, dv_dq[NW][i][DMW-1:0]});
      end
      sg_post.zl   <= dv_side[NW].zl;
      sg_post.zr   <= dv_side[NW].zr;
      sg_post.sat  <= 1'b0;
      sg_post.sneg <= 1'b0;
      sg_vel       <= dv_side[NW].vel;
      sg_emag      <= dv_dq[NW][LANE_E];
      sg_eneg      <= dv_eneg[NW];
      sg_kst       <= dv_side[NW].kst;
      sg_dmp       <= dv_side[NW].dmp;
    end
  end

  // --------------------------------------------------------------------------
  // A1..A3: relative velocity along dir, strain * stiffness
  // --------------------------------------------------------------------------
  post_t                  a1_post;
  logic signed [F+DW+1:0] a1_p [0:2];
  logic [EH+DW-2:0]       a1_el;
  logic [NW-EH+DW-2:0]    a1_eh;
  logic                   a1_eneg;
  logic [DW-2:0]          a1_dmp;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_post <= sg_post;
      for (int i = 0; i < 3; i++) begin
        a1_p[i] <= sg_dir[i] * $signed(sg_vel[i]);
      end
      a1_el   <= sg_emag[EH-1:0] * sg_kst;
      a1_eh   <= sg_emag[NW-1:EH] * sg_kst;
      a1_eneg <= sg_eneg;
      a1_dmp  <= sg_dmp;
    end
  end

  post_t                 a2_post;
  logic signed [PSW-1:0] a2_psum;
  logic [EKW-F-1:0]      a2_ek;
  logic [EKW-1:0]        ek_full;
  logic                  a2_eneg;
  logic [DW-2:0]         a2_dmp;

  assign ek_full = (EKW'(a1_eh) << EH) + EKW'(a1_el);

  always_ff @(posedge clk) begin
    if (en) begin
      a2_post <= a1_post;
      a2_psum <= PSW'(a1_p[0]) + PSW'(a1_p[1]) + PSW'(a1_p[2]);
      a2_ek   <= ek_full[EKW-1:F];
      a2_eneg <= a1_eneg;
      a2_dmp  <= a1_dmp;
    end
  end

  // rv is truncated toward zero: take the magnitude, then shift
  post_t              a3_post;
  logic               a3_rvneg;
  logic [RVW-1:0]     a3_rvmag;
  logic signed [63:0] a3_ek;
  logic [DW-2:0]      a3_dmp;
  logic [PSW-1:0]     pmag;
  logic [63:0]        ek_wide;
  logic               ek_sat;
  logic [63:0]        ek_mag;
  post_t              a2_post_sat;

  always_comb begin
    pmag    = a2_psum[PSW-1] ? PSW'(-a2_psum) : PSW'(a2_psum);
    ek_wide = 64'(a2_ek);
    ek_sat  = (ek_wide > dsf_pkg::MID_LIMIT);
    ek_mag  = ek_sat ? dsf_pkg::MID_LIMIT : ek_wide;
    a2_post_sat     = a2_post;
    a2_post_sat.sat = a2_post.sat || ek_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_post     <= a2_post_sat;
      a3_rvneg    <= a2_psum[PSW-1];
      a3_rvmag    <= pmag[F+RVW-1:F];
      a3_ek       <= a2_eneg ? -$signed(ek_mag) : $signed(ek_mag);
      a3_dmp      <= a2_dmp;
    end
  end

  // --------------------------------------------------------------------------
  // B1..B3: rv * damping
  // --------------------------------------------------------------------------
  post_t                b1_post;
  logic [RH+DW-2:0]     b1_rl;
  logic [RVW-RH+DW-2:0] b1_rh;
  logic                 b1_rvneg;
  logic signed [63:0]   b1_ek;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_post  <= a3_post;
      b1_rl    <= a3_rvmag[RH-1:0] * a3_dmp;
      b1_rh    <= a3_rvmag[RVW-1:RH] * a3_dmp;
      b1_rvneg <= a3_rvneg;
      b1_ek    <= a3_ek;
    end
  end

  post_t              b2_post;
  logic [RCW-F-1:0]   b2_rc;
  logic [RCW-1:0]     rc_full;
  logic               b2_rvneg;
  logic signed [63:0] b2_ek;

  assign rc_full = (RCW'(b1_rh) << RH) + RCW'(b1_rl);

  always_ff @(posedge clk) begin
    if (en) begin
      b2_post  <= b1_post;
      b2_rc    <= rc_full[RCW-1:F];
      b2_rvneg <= b1_rvneg;
      b2_ek    <= b1_ek;
    end
  end

  post_t              b3_post;
  logic signed [63:0] b3_ek;
  logic signed [63:0] b3_rc;
  logic [63:0]        rc_wide;
  logic               rc_sat;
  logic [63:0]        rc_mag;
  post_t              b2_post_sat;

  always_comb begin
    rc_wide = 64'(b2_rc);
    rc_sat  = (rc_wide > dsf_pkg::MID_LIMIT);
    rc_mag  = rc_sat ? dsf_pkg::MID_LIMIT : rc_wide;
    b2_post_sat     = b2_post;
    b2_post_sat.sat = b2_post.sat || rc_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_post     <= b2_post_sat;
      b3_ek       <= b2_ek;
      b3_rc       <= b2_rvneg ? -$signed(rc_mag) : $signed(rc_mag);
    end
  end

  // --------------------------------------------------------------------------
  // Scalar force s = ek + rc, then its magnitude
  // --------------------------------------------------------------------------
  post_t              s_post;
  logic signed [63:0] s_sum;
  post_t              s_post_sgn;
  post_t              m_post;
  logic [SMW-1:0]     m_smag;

  always_comb begin
    s_post_sgn      = s_post;
    s_post_sgn.sneg = s_sum[63];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_post      <= b3_post;
      s_sum       <= b3_ek + b3_rc;
      m_post      <= s_post_sgn;
      m_smag      <= s_sum[63] ? SMW'(-s_sum) : s_sum[SMW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // F1..F2: s * dir per lane, split product
  // --------------------------------------------------------------------------
  post_t                f1_post;
  logic [SLO+DMW-1:0]   f1_lo [0:2];
  logic [SMW-SLO+DMW-1:0] f1_hi [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      f1_post <= m_post;
      for (int i = 0; i < 3; i++) begin
        f1_lo[i] <= m_smag[SLO-1:0] * m_post.dirmag[i];
        f1_hi[i] <= m_smag[SMW-1:SLO] * m_post.dirmag[i];
      end
    end
  end

  post_t          f2_post;
  logic [63:0]    f2_mag [0:2];
  logic [FPW-1:0] f_full [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_full[i] = (FPW'(f1_hi[i]) << SLO) + FPW'(f1_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_post <= f1_post;
      for (int i = 0; i < 3; i++) begin
        f2_mag[i] <= f_full[i][FPW-1:F];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output: clamp to DW bits, apply sign, pick status
  // --------------------------------------------------------------------------
  logic               o_neg [0:2];
  logic [63:0]        o_lim [0:2];
  logic               o_sat [0:2];
  logic signed [63:0] o_val [0:2];
  logic               any_sat;
  dsf_pkg::status_t   o_status;
  logic               o_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_neg[i] = f2_post.sneg != f2_post.dirneg[i];
      o_lim[i] = o_neg[i] ? HALF_RANGE : (HALF_RANGE - 64'(1));
      o_sat[i] = (f2_mag[i] > o_lim[i]);
      o_val[i] = $signed(o_sat[i] ? o_lim[i] : f2_mag[i]);
      if (o_neg[i]) begin
        o_val[i] = -o_val[i];
      end
    end
    any_sat = f2_post.sat || o_sat[0] || o_sat[1] || o_sat[2];
    o_zero  = f2_post.zl || f2_post.zr;
    if (f2_post.zl) begin
      o_status = dsf_pkg::ST_ZERO_LEN;
    end else if (f2_post.zr) begin
      o_status = dsf_pkg::ST_ZERO_REST;
    end else if (any_sat) begin
      o_status = dsf_pkg::ST_SAT;
    end else begin
      o_status = dsf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      forces.force_x <= o_zero ? '0 : o_val[0][31:0];
      forces.force_y <= o_zero ? '0 : o_val[1][31:0];
      forces.force_z <= o_zero ? '0 : o_val[2][31:0];
      forces.status  <= o_status;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic out_special;
  logic out_zero;

  assign out_special = forces.valid && (forces.status == dsf_pkg::ST_ZERO_LEN ||
                                        forces.status == dsf_pkg::ST_ZERO_REST);
  assign out_zero    = (forces.force_x == '0) && (forces.force_y == '0) &&
                       (forces.force_z == '0);

  `DSF_CHECK(a_stall_blocks_input, clk, rst, forces.valid && !forces.ready, !springs.ready)
  `DSF_CHECK(a_special_zero_force, clk, rst, out_special, out_zero)
  `DSF_CHECK_NEXT(a_reset_empties_pipe, clk, rst, !forces.valid && vld == '0)

endmodule

`default_nettype wire
